// File: rtl/core/cc3_pkg.sv
package cc3_pkg;

    localparam int COORD_W = 12;
    localparam int OUT_W   = 32;
    localparam int FRAC_W  = 8;

    // Working widths, all derived from the coordinate, output and fraction widths.
    localparam int DW   = COORD_W + 1;          // edge vectors a = P2-P1, b = P3-P1
    localparam int NW   = 2 * DW + 1;           // normal n = a x b
    localparam int SQW  = 2 * DW + 2;           // |a|^2, |b|^2
    localparam int WW   = SQW + DW + 1;         // w = |a|^2 b - |b|^2 a
    localparam int CXW  = WW + NW + 1;          // (w x n) components
    localparam int DENW = 2 * NW + 3;           // 2|n|^2
    localparam int DPW  = DENW + COORD_W;       // 2|n|^2 * P1
    localparam int NUMW = ((DPW > CXW) ? DPW : CXW) + 1;
    localparam int NSW  = NUMW + FRAC_W;        // numerator scaled to Q format
    localparam int RW   = (DENW + OUT_W > NSW) ? DENW + OUT_W : NSW;

    // Operand splits for the wide products
    localparam int WLO = WW / 2;
    localparam int WHI = WW - WLO;
    localparam int DLO = DENW / 2;
    localparam int DHI = DENW - DLO;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    localparam int PRE_DIV = 7;                 // back-end stages ahead of the dividers
    localparam int BACK_STAGES = PRE_DIV + OUT_W + 2;

    typedef struct packed {
        logic signed [COORD_W-1:0] p1_x;
        logic signed [COORD_W-1:0] p1_y;
        logic signed [COORD_W-1:0] p1_z;
        logic signed [COORD_W-1:0] p2_x;
        logic signed [COORD_W-1:0] p2_y;
        logic signed [COORD_W-1:0] p2_z;
        logic signed [COORD_W-1:0] p3_x;
        logic signed [COORD_W-1:0] p3_y;
        logic signed [COORD_W-1:0] p3_z;
    } in_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] center_x;
        logic signed [OUT_W-1:0] center_y;
        logic signed [OUT_W-1:0] center_z;
        logic                    degenerate;
        logic                    saturated;
    } out_t;

    // Item handed from the front end to the back end; index 0 is x.
    typedef struct packed {
        logic [2:0][COORD_W-1:0] p1;
        logic [2:0][DW-1:0]      a;
        logic [2:0][DW-1:0]      b;
        logic [2:0][NW-1:0]      n;
        logic [SQW-1:0]          aa;
        logic [SQW-1:0]          bb;
        logic                    deg;
    } mid_t;

endpackage

// File: rtl/core/cc3_front.sv
module cc3_front
    import cc3_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  in_t  in_data,
    output logic push_valid,
    input  logic push_ready,
    output mid_t push_data
);

    logic en;
    logic v1_reg, v2_reg, v3_reg;

    logic signed [COORD_W-1:0] p1_in [3];
    logic signed [COORD_W-1:0] p2_in [3];
    logic signed [COORD_W-1:0] p3_in [3];

    logic signed [COORD_W-1:0] p1_1_reg [3];
    logic signed [COORD_W-1:0] p1_2_reg [3];
    logic signed [COORD_W-1:0] p1_3_reg [3];
    logic signed [DW-1:0]      a1_reg [3];
    logic signed [DW-1:0]      b1_reg [3];
    logic signed [DW-1:0]      a2_reg [3];
    logic signed [DW-1:0]      b2_reg [3];
    logic signed [DW-1:0]      a3_reg [3];
    logic signed [DW-1:0]      b3_reg [3];
    logic signed [2*DW-1:0]    xa_reg [3];
    logic signed [2*DW-1:0]    xb_reg [3];
    logic signed [2*DW-1:0]    sqa_reg [3];
    logic signed [2*DW-1:0]    sqb_reg [3];
    logic signed [NW-1:0]      n_reg [3];
    logic signed [SQW-1:0]     aa_reg;
    logic signed [SQW-1:0]     bb_reg;

    assign en       = !v3_reg || push_ready;
    assign in_ready = en;

    always_comb
    begin
        p1_in[0] = in_data.p1_x;
        p1_in[1] = in_data.p1_y;
        p1_in[2] = in_data.p1_z;
        p2_in[0] = in_data.p2_x;
        p2_in[1] = in_data.p2_y;
        p2_in[2] = in_data.p2_z;
        p3_in[0] = in_data.p3_x;
        p3_in[1] = in_data.p3_y;
        p3_in[2] = in_data.p3_z;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        localparam int J = (i + 1) % 3;
        localparam int K = (i + 2) % 3;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                p1_1_reg[i] <= p1_in[i];
                a1_reg[i]   <= DW'(p2_in[i]) - DW'(p1_in[i]);
                b1_reg[i]   <= DW'(p3_in[i]) - DW'(p1_in[i]);

                p1_2_reg[i] <= p1_1_reg[i];
                a2_reg[i]   <= a1_reg[i];
                b2_reg[i]   <= b1_reg[i];
                xa_reg[i]   <= a1_reg[J] * b1_reg[K];
                xb_reg[i]   <= a1_reg[K] * b1_reg[J];
                sqa_reg[i]  <= a1_reg[i] * a1_reg[i];
                sqb_reg[i]  <= b1_reg[i] * b1_reg[i];

                p1_3_reg[i] <= p1_2_reg[i];
                a3_reg[i]   <= a2_reg[i];
                b3_reg[i]   <= b2_reg[i];
                n_reg[i]    <= NW'(xa_reg[i]) - NW'(xb_reg[i]);
            end
        end

        assign push_data.p1[i] = p1_3_reg[i];
        assign push_data.a[i]  = a3_reg[i];
        assign push_data.b[i]  = b3_reg[i];
        assign push_data.n[i]  = n_reg[i];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            aa_reg <= SQW'(sqa_reg[0]) + SQW'(sqa_reg[1]) + SQW'(sqa_reg[2]);
            bb_reg <= SQW'(sqb_reg[0]) + SQW'(sqb_reg[1]) + SQW'(sqb_reg[2]);
        end
    end

    // collinear or coincident points leave a zero normal
    assign push_data.aa  = aa_reg;
    assign push_data.bb  = bb_reg;
    assign push_data.deg = (n_reg[0] == '0) && (n_reg[1] == '0) && (n_reg[2] == '0);
    assign push_valid    = v3_reg;

endmodule

// File: rtl/core/cc3_queue.sv
module cc3_queue
    import cc3_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  mid_t push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output mid_t pop_data
);

    mid_t           mem_reg [QDEPTH];
    logic [QAW-1:0] wr_reg, wr_next;
    logic [QAW-1:0] rd_reg, rd_next;
    logic [QAW:0]   cnt_reg, cnt_next;
    logic           push, pop;

    assign push_ready = (cnt_reg != QAW'(0) + (QAW+1)'(QDEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (QAW+1)'(QDEPTH))
        else $error("queue count beyond depth");

    a_cnt_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("queue count missed a transfer in");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (QAW'(wr_reg - rd_reg) == cnt_reg[QAW-1:0]))
        else $error("queue pointers disagree with count");

endmodule

// File: rtl/core/cc3_div.sv
module cc3_div
    import cc3_pkg::*;
(
    input  logic                    clk,
    input  logic                    en,
    input  logic [NSW-1:0]          mag,
    input  logic                    neg,
    input  logic [DENW-1:0]         den,
    output logic signed [OUT_W-1:0] res,
    output logic                    sat
);

    localparam logic [OUT_W-1:0] POS_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] NEG_MAG = {1'b1, {(OUT_W-1){1'b0}}};

    logic [RW-1:0]    r_reg   [OUT_W+1];
    logic [OUT_W-1:0] q_reg   [OUT_W+1];
    logic [DENW-1:0]  d_reg   [OUT_W+1];
    logic             neg_reg [OUT_W+1];
    logic             ovf_reg [OUT_W+1];
    logic [RW-1:0]    dsh     [OUT_W];
    logic             ge      [OUT_W];
    logic             ovf_in;
    logic [OUT_W-1:0] qf;
    logic [OUT_W-1:0] res_next;
    logic             sat_next;
    logic [OUT_W-1:0] res_reg;
    logic             sat_reg;

    // quotient does not fit OUT_W bits when mag >= den * 2^OUT_W
    assign ovf_in = RW'(mag) >= (RW'(den) << OUT_W);

    always_comb
    begin
        for (int s = 0; s < OUT_W; s++)
        begin
            dsh[s] = RW'(d_reg[s]) << (OUT_W - 1 - s);
            ge[s]  = r_reg[s] >= dsh[s];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0]   <= RW'(mag);
            q_reg[0]   <= '0;
            d_reg[0]   <= den;
            neg_reg[0] <= neg;
            ovf_reg[0] <= ovf_in;
            for (int s = 0; s < OUT_W; s++)
            begin
                r_reg[s+1]   <= ge[s] ? r_reg[s] - dsh[s] : r_reg[s];
                q_reg[s+1]   <= {q_reg[s][OUT_W-2:0], ge[s]};
                d_reg[s+1]   <= d_reg[s];
                neg_reg[s+1] <= neg_reg[s];
                ovf_reg[s+1] <= ovf_reg[s];
            end
        end
    end

    always_comb
    begin
        qf = q_reg[OUT_W];
        if (!neg_reg[OUT_W])
        begin
            sat_next = ovf_reg[OUT_W] || (qf > POS_MAX);
            res_next = sat_next ? POS_MAX : qf;
        end
        else
        begin
            sat_next = ovf_reg[OUT_W] || (qf > NEG_MAG);
            res_next = sat_next ? NEG_MAG : (~qf + 1'b1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
            sat_reg <= sat_next;
        end
    end

    assign res = $signed(res_reg);
    assign sat = sat_reg;

endmodule

// File: rtl/core/cc3_back.sv
module cc3_back
    import cc3_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic pop_valid,
    output logic pop_ready,
    input  mid_t pop_data,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_data
);

    logic en;
    logic [BACK_STAGES-1:0] vld_reg;
    logic [BACK_STAGES-1:0] deg_reg;

    logic signed [DW-1:0]      a_in [3];
    logic signed [DW-1:0]      b_in [3];
    logic signed [NW-1:0]      n_in [3];
    logic signed [SQW-1:0]     aa_in, bb_in;

    // B1
    logic signed [SQW+DW-1:0]  ab_reg [3];
    logic signed [SQW+DW-1:0]  ba_reg [3];
    logic signed [2*NW-1:0]    nsq_reg [3];
    logic signed [NW-1:0]      n1_reg [3];
    logic signed [COORD_W-1:0] p1a_reg [3];
    // B2
    logic signed [WW-1:0]      w_reg [3];
    logic signed [NW-1:0]      n2_reg [3];
    logic signed [COORD_W-1:0] p1b_reg [3];
    // B3
    logic signed [WLO+NW:0]    pl_reg [3];
    logic signed [WHI+NW-1:0]  ph_reg [3];
    logic signed [WLO+NW:0]    ml_reg [3];
    logic signed [WHI+NW-1:0]  mh_reg [3];
    logic signed [DLO+COORD_W:0]   dl_reg [3];
    logic signed [DHI+COORD_W-1:0] dh_reg [3];
    // B4
    logic signed [CXW-1:0]     pp_reg [3];
    logic signed [CXW-1:0]     mm_reg [3];
    logic signed [DPW-1:0]     dp4_reg [3];
    // B5
    logic signed [CXW-1:0]     cx_reg [3];
    logic signed [DPW-1:0]     dp5_reg [3];
    // B6
    logic signed [NUMW-1:0]    num_reg [3];
    // B7
    logic [NSW-1:0]            mag_reg [3];
    logic                      neg_reg [3];

    // denominator 2|n|^2, one copy per stage from B2 through B7
    logic signed [DENW-1:0]    den_reg [6];

    logic signed [OUT_W-1:0]   res [3];
    logic                      sat [3];
    logic                      deg_out;

    assign en        = !out_valid || out_ready;
    assign pop_ready = en;

    assign aa_in = $signed(pop_data.aa);
    assign bb_in = $signed(pop_data.bb);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[BACK_STAGES-2:0], pop_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            deg_reg    <= {deg_reg[BACK_STAGES-2:0], pop_data.deg};
            den_reg[0] <= (DENW'(nsq_reg[0]) + DENW'(nsq_reg[1]) + DENW'(nsq_reg[2])) <<< 1;
            for (int s = 1; s < 6; s++)
            begin
                den_reg[s] <= den_reg[s-1];
            end
        end
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        localparam int J = (i + 1) % 3;
        localparam int K = (i + 2) % 3;

        assign a_in[i] = $signed(pop_data.a[i]);
        assign b_in[i] = $signed(pop_data.b[i]);
        assign n_in[i] = $signed(pop_data.n[i]);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ab_reg[i]  <= aa_in * b_in[i];
                ba_reg[i]  <= bb_in * a_in[i];
                nsq_reg[i] <= n_in[i] * n_in[i];
                n1_reg[i]  <= n_in[i];
                p1a_reg[i] <= $signed(pop_data.p1[i]);

                w_reg[i]   <= WW'(ab_reg[i]) - WW'(ba_reg[i]);
                n2_reg[i]  <= n1_reg[i];
                p1b_reg[i] <= p1a_reg[i];

                // split the wide operand so each product stays narrow
                pl_reg[i] <= $signed({1'b0, w_reg[J][WLO-1:0]}) * n2_reg[K];
                ph_reg[i] <= $signed(w_reg[J][WW-1:WLO]) * n2_reg[K];
                ml_reg[i] <= $signed({1'b0, w_reg[K][WLO-1:0]}) * n2_reg[J];
                mh_reg[i] <= $signed(w_reg[K][WW-1:WLO]) * n2_reg[J];
                dl_reg[i] <= $signed({1'b0, den_reg[0][DLO-1:0]}) * p1b_reg[i];
                dh_reg[i] <= $signed(den_reg[0][DENW-1:DLO]) * p1b_reg[i];

                pp_reg[i]  <= (CXW'(ph_reg[i]) <<< WLO) + CXW'(pl_reg[i]);
                mm_reg[i]  <= (CXW'(mh_reg[i]) <<< WLO) + CXW'(ml_reg[i]);
                dp4_reg[i] <= (DPW'(dh_reg[i]) <<< DLO) + DPW'(dl_reg[i]);

                cx_reg[i]  <= pp_reg[i] - mm_reg[i];
                dp5_reg[i] <= dp4_reg[i];

                num_reg[i] <= NUMW'(dp5_reg[i]) + NUMW'(cx_reg[i]);

                neg_reg[i] <= num_reg[i][NUMW-1];
                mag_reg[i] <= num_reg[i][NUMW-1] ? -(NSW'(num_reg[i]) <<< FRAC_W)
                                                 : (NSW'(num_reg[i]) <<< FRAC_W);
            end
        end

        cc3_div u_div (
            .clk (clk),
            .en  (en),
            .mag (mag_reg[i]),
            .neg (neg_reg[i]),
            .den (den_reg[5]),
            .res (res[i]),
            .sat (sat[i])
        );
    end

    // a zero normal (degenerate item) overrides whatever the dividers produced
    assign deg_out    = deg_reg[BACK_STAGES-1];
    assign out_valid  = vld_reg[BACK_STAGES-1];
    assign out_data.center_x   = deg_out ? '0 : res[0];
    assign out_data.center_y   = deg_out ? '0 : res[1];
    assign out_data.center_z   = deg_out ? '0 : res[2];
    assign out_data.degenerate = deg_out;
    assign out_data.saturated  = !deg_out && (sat[0] || sat[1] || sat[2]);

endmodule

// File: rtl/core/circumcenter_3d.sv
// Circumcenter of three 3D points with integer coordinates.
// Input channel: in_valid/in_ready carry one in_t per transfer (three points).
// Output channel: out_valid/out_ready carry one out_t per transfer: the center
// in signed Q8, a degenerate flag for collinear or coincident points (center
// reads zero) and a saturated flag when a coordinate was clipped to range.
// Throughput: one item per cycle. A front pipeline (3 stages) forms edge
// vectors, normal and squared lengths; a 4-entry queue feeds a back pipeline
// of 41 stages: 7 multiply/add stages, then three restoring dividers that
// retire one quotient bit per stage (32 stages plus range check and clip).
// Reset clears all valid state; the pipelines come up empty and in_ready is
// high. When the receiver holds out_ready low, the back pipeline stalls in
// place, the queue fills, and then the front stalls and drops in_ready.
module circumcenter_3d
    import cc3_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  in_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_data
);

    logic push_valid, push_ready;
    logic pop_valid, pop_ready;
    mid_t push_data, pop_data;

    cc3_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    cc3_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    cc3_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
